/* design/pqrs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Piece queue with reserve stack: shared package
// Depths, derived widths, operation and status codes, and the request,
// response and control types that the block's modules share.
// ----------------------------------------------------------------------------
package pqrs_pkg;

	localparam int QUEUE_DEPTH = 5;
	localparam int STACK_DEPTH = 3;

	localparam int QIDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QFILL_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SIDX_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int SFILL_W = $clog2(STACK_DEPTH + 1);

	localparam int KIND_W   = 2;
	localparam int ID_W     = 16;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 3;
	localparam int QCNT_W   = 3;
	localparam int SCNT_W   = 2;

	typedef enum logic [OP_W-1:0] {
		OP_FILL    = 2'd0,
		OP_PLAY    = 2'd1,
		OP_RESERVE = 2'd2,
		OP_USE     = 2'd3
	} pq_op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 3'd0,
		ST_QUEUE_EMPTY = 3'd1,
		ST_STACK_FULL  = 3'd2,
		ST_STACK_EMPTY = 3'd3,
		ST_QUEUE_FULL  = 3'd4
	} pq_status_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ID_W-1:0]   id;
	} pq_piece_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [KIND_W-1:0] new_kind;
		logic [ID_W-1:0]   new_id;
	} pq_req_t;

	typedef struct packed {
		logic [KIND_W-1:0]   piece_kind;
		logic [ID_W-1:0]     piece_id;
		logic [STATUS_W-1:0] status;
		logic [QCNT_W-1:0]   queue_count;
		logic [SCNT_W-1:0]   stack_count;
	} pq_rsp_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} pq_cmd_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} pq_state_t;

endpackage
`default_nettype wire

/* design/pqrs_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Piece queue with reserve stack: datapath
// Holds the request register, the circular queue, the reserve stack and the
// response register, and performs one operation when commanded.
// ----------------------------------------------------------------------------
module pqrs_dp
	import pqrs_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire pq_cmd_t cmd,
	input  wire pq_req_t req,
	output pq_rsp_t      rsp
);

	pq_req_t             req_q;
	pq_rsp_t             rsp_q;
	pq_piece_t           queue_q [QUEUE_DEPTH];
	pq_piece_t           stack_q [STACK_DEPTH];
	logic [QIDX_W-1:0]   head_q;
	logic [QIDX_W-1:0]   tail_q;
	logic [QFILL_W-1:0]  qfill_q;
	logic [SFILL_W-1:0]  sfill_q;

	logic                pop;
	logic                push;
	logic                spush;
	logic                spop;
	pq_status_t          status;
	pq_piece_t           piece;
	pq_piece_t           head_piece;
	pq_piece_t           top_piece;
	pq_piece_t           new_piece;
	logic [QIDX_W-1:0]   head_nx;
	logic [QIDX_W-1:0]   tail_nx;
	logic [QFILL_W-1:0]  qfill_nx;
	logic [SFILL_W-1:0]  sfill_nx;
	logic [SFILL_W-1:0]  sfill_dec;
	logic [SIDX_W-1:0]   top_idx;
	logic [SIDX_W-1:0]   wr_idx;
	logic                q_full;
	logic                q_empty;
	logic                s_full;
	logic                s_empty;

	function automatic logic [QIDX_W-1:0] next_slot(input logic [QIDX_W-1:0] idx);
		logic [QIDX_W-1:0] r;
		if (idx == QIDX_W'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = idx + 1'b1;
		end
		return r;
	endfunction

	assign sfill_dec  = sfill_q - 1'b1;
	assign top_idx    = SIDX_W'(sfill_dec);
	assign wr_idx     = SIDX_W'(sfill_q);
	assign head_piece = queue_q[head_q];
	assign top_piece  = stack_q[top_idx];
	assign new_piece  = '{kind: req_q.new_kind, id: req_q.new_id};
	assign head_nx    = next_slot(head_q);
	assign tail_nx    = next_slot(tail_q);
	assign q_full     = (qfill_q == QFILL_W'(QUEUE_DEPTH));
	assign q_empty    = (qfill_q == '0);
	assign s_full     = (sfill_q == SFILL_W'(STACK_DEPTH));
	assign s_empty    = (sfill_q == '0);

	always_comb begin
		pop    = 1'b0;
		push   = 1'b0;
		spush  = 1'b0;
		spop   = 1'b0;
		status = ST_OK;
		piece  = '0;
		case (req_q.op)
			OP_FILL: begin
				if (q_full) begin
					status = ST_QUEUE_FULL;
				end else begin
					push = 1'b1;
				end
			end
			OP_PLAY: begin
				if (q_empty) begin
					status = ST_QUEUE_EMPTY;
				end else begin
					pop   = 1'b1;
					push  = 1'b1;
					piece = head_piece;
				end
			end
			OP_RESERVE: begin
				if (q_empty) begin
					status = ST_QUEUE_EMPTY;
				end else if (s_full) begin
					status = ST_STACK_FULL;
				end else begin
					pop   = 1'b1;
					push  = 1'b1;
					spush = 1'b1;
					piece = head_piece;
				end
			end
			OP_USE: begin
				if (s_empty) begin
					status = ST_STACK_EMPTY;
				end else begin
					spop  = 1'b1;
					piece = top_piece;
				end
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

	always_comb begin
		qfill_nx = qfill_q;
		if (push && !pop) begin
			qfill_nx = qfill_q + 1'b1;
		end
		sfill_nx = sfill_q;
		if (spush) begin
			sfill_nx = sfill_q + 1'b1;
		end else if (spop) begin
			sfill_nx = sfill_dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= QIDX_W'(QUEUE_DEPTH - 1);
			qfill_q <= '0;
			sfill_q <= '0;
		end else if (cmd.execute) begin
			if (pop) begin
				head_q <= head_nx;
			end
			if (push) begin
				tail_q <= tail_nx;
			end
			qfill_q <= qfill_nx;
			sfill_q <= sfill_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
		if (cmd.execute) begin
			rsp_q.piece_kind  <= piece.kind;
			rsp_q.piece_id    <= piece.id;
			rsp_q.status      <= status;
			rsp_q.queue_count <= QCNT_W'(qfill_nx);
			rsp_q.stack_count <= SCNT_W'(sfill_nx);
			if (push) begin
				queue_q[tail_nx] <= new_piece;
			end
			if (spush) begin
				stack_q[wr_idx] <= head_piece;
			end
		end
	end

	assign rsp = rsp_q;

endmodule
`default_nettype wire

/* design/pqrs_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Piece queue with reserve stack: controller
// Sequences each transaction from request capture to execution and owns the
// response valid flag.
// ----------------------------------------------------------------------------
module pqrs_ctrl
	import pqrs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output pq_cmd_t   cmd
);

	pq_state_t state_q;
	pq_state_t state_d;
	logic      out_valid_q;
	logic      out_valid_d;
	logic      out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		out_free    = !out_valid_q || !rsp_stall;
		req_stall   = 1'b0;
		out_valid_d = out_valid_q && rsp_stall;
		case (state_q)
			S_IDLE: begin
				cmd.capture = req_valid;
				if (req_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				req_stall = 1'b1;
				if (out_free) begin
					cmd.execute = 1'b1;
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign rsp_valid = out_valid_q;

	a_exec_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.execute |=> rsp_valid)
		else $error("Executed transaction did not present a response.");

	a_capture_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == S_EXEC))
		else $error("Captured request did not move to execution.");

	a_wait_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_EXEC) && !cmd.execute) |-> (out_valid_q && rsp_stall))
		else $error("Execution held back without a blocked response.");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && rsp_stall) |-> !cmd.execute)
		else $error("Response overwritten while stalled.");

endmodule
`default_nettype wire

/* design/piece_queue_with_reserve_stack_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Piece queue with reserve stack: top level
// Circular queue of pieces with a reserve stack; one response per request.
// ----------------------------------------------------------------------------
// Each request is first registered; the datapath then reads the queue head or
// stack top from its register files, updates the pointers and counts and loads
// the response register. A new request is taken while the previous response
// waits in that register, so a stalled response costs throughput only once the
// next request is ready to execute. Storage needs no clearing after reset.
module piece_queue_with_reserve_stack_top
	import pqrs_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    req_valid,
	output logic         req_stall,
	input  wire pq_req_t req,
	output logic         rsp_valid,
	input  wire logic    rsp_stall,
	output pq_rsp_t      rsp
);

	pq_cmd_t cmd;

	pqrs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	pqrs_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule
`default_nettype wire
